[sv/wat2_pkg.sv]
// shared types, constants and candidate lookup for the weighted alarm top-two selector
// no dependencies; used by wat2_cell and weighted_alarm_top_two_selector_core

package wat2_pkg;

    // field widths
    localparam int LEVEL_W       = 24;
    localparam int LEVEL_IDX_W   = $clog2(LEVEL_W);
    localparam int CODE_W        = 6;
    localparam int WEIGHT_W      = 4;
    localparam int LINE_COUNT_DEF = 24;

    // candidate slots ahead of the per-line slots
    localparam int SLOT_COMBO_LOW  = 0;
    localparam int SLOT_COMBO_HIGH = 1;
    localparam int SLOT_LINE0      = 2;

    // weights
    localparam logic [WEIGHT_W-1:0] W_COMBO_LOW  = 4'd12;
    localparam logic [WEIGHT_W-1:0] W_COMBO_HIGH = 4'd15;
    localparam logic [WEIGHT_W-1:0] W_BIT23_LOW  = 4'd10;
    localparam logic [WEIGHT_W-1:0] W_BIT9_HIGH  = 4'd7;
    localparam logic [WEIGHT_W-1:0] W_BIT0_LOW   = 4'd5;
    localparam logic [WEIGHT_W-1:0] W_OTHER_HIGH = 4'd3;
    localparam logic [WEIGHT_W-1:0] W_OTHER_LOW  = 4'd1;

    // running top-two ranking carried down the chain
    typedef struct packed {
        logic [CODE_W-1:0]   top_code;
        logic [WEIGHT_W-1:0] top_weight;
        logic                top_is_combo_high;
        logic [CODE_W-1:0]   next_code;
        logic [WEIGHT_W-1:0] next_weight;
    } rank_t;

    // one candidate message
    typedef struct packed {
        logic                present;
        logic [CODE_W-1:0]   code;
        logic [WEIGHT_W-1:0] weight;
        logic                is_combo_high;
    } cand_t;

    // level of one line; lines past the input or past the line count read low
    function automatic logic line_hi(input logic [LEVEL_W-1:0] lv, input int unsigned idx,
                                     input int unsigned n);
        logic r;
        r = 1'b0;
        if (idx < LEVEL_W && idx < n) begin
            r = lv[idx[LEVEL_IDX_W-1:0]];
        end
        return r;
    endfunction

    // candidate for a slot: combos first, then lines 0 upward
    function automatic cand_t cand_of(input int unsigned slot, input logic [LEVEL_W-1:0] lv,
                                      input int unsigned n);
        cand_t       c;
        logic        hi;
        int unsigned li;
        logic [31:0] code32;
        c      = '0;
        hi     = 1'b0;
        li     = 0;
        code32 = '0;
        if (slot == SLOT_COMBO_LOW) begin
            c.present = (n > 15) && !line_hi(lv, 13, n) && !line_hi(lv, 14, n)
                        && !line_hi(lv, 15, n);
            code32    = 32'(2 * n);
            c.weight  = W_COMBO_LOW;
        end else if (slot == SLOT_COMBO_HIGH) begin
            c.present       = (n > 11) && line_hi(lv, 10, n) && line_hi(lv, 11, n);
            code32          = 32'(2 * n + 1);
            c.weight        = W_COMBO_HIGH;
            c.is_combo_high = 1'b1;
        end else begin
            li        = slot - SLOT_LINE0;
            hi        = line_hi(lv, li, n);
            c.present = 1'b1;
            code32    = hi ? 32'(n + li) : 32'(li);
            if (hi) begin
                c.weight = (li == 9) ? W_BIT9_HIGH : W_OTHER_HIGH;
            end else if (li == 0) begin
                c.weight = W_BIT0_LOW;
            end else if (li == 23) begin
                c.weight = W_BIT23_LOW;
            end else begin
                c.weight = W_OTHER_LOW;
            end
        end
        c.code = code32[CODE_W-1:0];
        return c;
    endfunction

endpackage

[sv/weighted_alarm_top_two_selector_core.sv]
// top level of the weighted alarm top-two selector: chain of ranking cells
// depends on wat2_pkg and wat2_cell

// Takes one sample of the monitored lines per transaction and returns the codes
// and weights of the two heaviest alarm messages plus an alert flag when the top
// one is the lines-10-and-11-high combination. Ties go to the earlier candidate:
// the 13-14-15-low combination, then the 10-11-high combination, then lines 0
// upward. The chain has one cell per candidate (LINE_COUNT + 2 cells), each
// with its own register, and a new sample is taken every cycle while the
// chain moves. When the result at the output is not taken, the whole chain
// holds, so s_tready follows m_tready then.

module weighted_alarm_top_two_selector_core
    import wat2_pkg::*;
#(
    parameter int LINE_COUNT = LINE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] line_levels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [5:0] first_code, [9:6] first_weight,
                                   // [15:10] second_code, [19:16] second_weight,
                                   // [20] alert, [23:21] zero
);

    localparam int NCELL = LINE_COUNT + SLOT_LINE0;

    logic               valid_chain  [0:NCELL];
    logic [LEVEL_W-1:0] levels_chain [0:NCELL];
    rank_t              rank_chain   [0:NCELL];
    logic               adv;
    rank_t              res;

    // whole chain moves unless the output holds an untaken result
    assign adv      = !valid_chain[NCELL] || m_tready;
    assign s_tready = adv;

    // chain entry
    assign valid_chain[0]  = s_tvalid;
    assign levels_chain[0] = s_tdata[LEVEL_W-1:0];
    assign rank_chain[0]   = '0;

    // one cell per candidate
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        wat2_cell #(
            .CAND_IDX   (k),
            .LINE_COUNT (LINE_COUNT)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .in_valid   (valid_chain[k]),
            .in_levels  (levels_chain[k]),
            .in_rank    (rank_chain[k]),
            .out_valid  (valid_chain[k+1]),
            .out_levels (levels_chain[k+1]),
            .out_rank   (rank_chain[k+1])
        );
    end

    // result packing
    assign res      = rank_chain[NCELL];
    assign m_tvalid = valid_chain[NCELL];
    assign m_tdata  = {3'b000, res.top_is_combo_high, res.next_weight, res.next_code,
                       res.top_weight, res.top_code};

    // alert only comes with the combination weight
    a_alert_weight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] |-> m_tdata[9:6] == W_COMBO_HIGH)
        else $error("alert without combination weight");

    // top is never lighter than second
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:6] >= m_tdata[19:16])
        else $error("ranking out of order");

    // at least two lines always give two candidates
    a_two_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:6] != '0 && m_tdata[19:16] != '0)
        else $error("missing candidate");

    // chain stalls only behind an untaken result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("stall without output back-pressure");

endmodule

[sv/wat2_cell.sv]
// one cell of the ranking chain: offers its candidate to the running top two
// depends on wat2_pkg

module wat2_cell
    import wat2_pkg::*;
#(
    parameter int CAND_IDX   = 0,
    parameter int LINE_COUNT = LINE_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [LEVEL_W-1:0] in_levels,
    input  rank_t              in_rank,
    output logic               out_valid,
    output logic [LEVEL_W-1:0] out_levels,
    output rank_t              out_rank
);

    logic               valid_reg;
    logic [LEVEL_W-1:0] levels_reg;
    rank_t              rank_reg;
    rank_t              rank_next;
    cand_t              cand;

    // candidate of this slot from the sample
    assign cand = cand_of(CAND_IDX, in_levels, LINE_COUNT);

    // insert into top two, earlier candidates win ties
    always_comb begin
        rank_next = in_rank;
        if (cand.present) begin
            if (cand.weight > in_rank.top_weight) begin
                rank_next.next_code         = in_rank.top_code;
                rank_next.next_weight       = in_rank.top_weight;
                rank_next.top_code          = cand.code;
                rank_next.top_weight        = cand.weight;
                rank_next.top_is_combo_high = cand.is_combo_high;
            end else if (cand.weight > in_rank.next_weight) begin
                rank_next.next_code   = cand.code;
                rank_next.next_weight = cand.weight;
            end
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            levels_reg <= in_levels;
            rank_reg   <= rank_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_levels = levels_reg;
    assign out_rank   = rank_reg;

endmodule

[tb/weighted_alarm_top_two_selector_core_tb.sv]
// self-checking testbench for weighted_alarm_top_two_selector_core: directed table, then shaped
// random samples in several idling phases; each result is checked by a typed row or the predictor
// depends on wat2_pkg and the core rtl only

`timescale 1ns / 1ps

module weighted_alarm_top_two_selector_core_tb
    import wat2_pkg::*;
();

    localparam int LINES           = LINE_COUNT_DEF;
    localparam int PIPE_LATENCY    = LINES + 2;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PER_PHASE = 380;

    // message codes used in the directed table
    localparam logic [CODE_W-1:0] CODE_COMBO_LOW  = CODE_W'(2 * LINES);
    localparam logic [CODE_W-1:0] CODE_COMBO_HIGH = CODE_W'(2 * LINES + 1);
    localparam logic [CODE_W-1:0] CODE_LINE0_LOW  = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_LINE23_LOW = CODE_W'(23);
    localparam logic [CODE_W-1:0] CODE_LINE0_HIGH = CODE_W'(LINES + 0);
    localparam logic [CODE_W-1:0] CODE_LINE9_HIGH = CODE_W'(LINES + 9);
    localparam logic [CODE_W-1:0] CODE_LINE13_HIGH = CODE_W'(LINES + 13);

    // one result transaction, unpacked from m_tdata
    typedef struct packed {
        logic [CODE_W-1:0]   first_code;
        logic [WEIGHT_W-1:0] first_weight;
        logic [CODE_W-1:0]   second_code;
        logic [WEIGHT_W-1:0] second_weight;
        logic                alert;
    } top_two_t;

    // directed row: sample, whether the result is typed in, and that result
    typedef struct packed {
        logic [LEVEL_W-1:0] levels;
        logic               typed;
        top_two_t           res;
    } dir_row_t;

    localparam int NUM_DIR = 25;
    localparam top_two_t NONE = '0;

    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        // all low, all high, combos and extremes
        {24'h000000, 1'b1, {CODE_COMBO_LOW,  W_COMBO_LOW,  CODE_LINE23_LOW, W_BIT23_LOW, 1'b0}},
        {24'hFFFFFF, 1'b1, {CODE_COMBO_HIGH, W_COMBO_HIGH, CODE_LINE9_HIGH, W_BIT9_HIGH, 1'b1}},
        {24'h000C00, 1'b1, {CODE_COMBO_HIGH, W_COMBO_HIGH, CODE_COMBO_LOW,  W_COMBO_LOW, 1'b1}},
        {24'h7FFFFF, 1'b1, {CODE_COMBO_HIGH, W_COMBO_HIGH, CODE_LINE23_LOW, W_BIT23_LOW, 1'b1}},
        {24'h00E000, 1'b1, {CODE_LINE23_LOW, W_BIT23_LOW,  CODE_LINE0_LOW,  W_BIT0_LOW,  1'b0}},
        {24'h80E201, 1'b1, {CODE_LINE9_HIGH, W_BIT9_HIGH,  CODE_LINE0_HIGH, W_OTHER_HIGH, 1'b0}},
        // equal weights: earlier line wins
        {24'h80E001, 1'b1, {CODE_LINE0_HIGH, W_OTHER_HIGH, CODE_LINE13_HIGH, W_OTHER_HIGH, 1'b0}},
        {24'h80E000, 1'b1, {CODE_LINE0_LOW,  W_BIT0_LOW,   CODE_LINE13_HIGH, W_OTHER_HIGH, 1'b0}},
        {24'hFFF7FF, 1'b1, {CODE_LINE9_HIGH, W_BIT9_HIGH,  CODE_LINE0_HIGH, W_OTHER_HIGH, 1'b0}},
        {24'h800000, 1'b1, {CODE_COMBO_LOW,  W_COMBO_LOW,  CODE_LINE0_LOW,  W_BIT0_LOW,  1'b0}},
        {24'h000200, 1'b1, {CODE_COMBO_LOW,  W_COMBO_LOW,  CODE_LINE23_LOW, W_BIT23_LOW, 1'b0}},
        {24'h80EC00, 1'b1, {CODE_COMBO_HIGH, W_COMBO_HIGH, CODE_LINE0_LOW,  W_BIT0_LOW,  1'b1}},
        // single lines and patterns, checked by the predictor
        {24'h000400, 1'b0, NONE},
        {24'h000800, 1'b0, NONE},
        {24'h002000, 1'b0, NONE},
        {24'h004000, 1'b0, NONE},
        {24'h008000, 1'b0, NONE},
        {24'h000001, 1'b0, NONE},
        {24'h400000, 1'b0, NONE},
        {24'h555555, 1'b0, NONE},
        {24'hAAAAAA, 1'b0, NONE},
        {24'h00DC00, 1'b0, NONE},
        {24'h0FFFFF, 1'b0, NONE},
        {24'hF00000, 1'b0, NONE},
        {24'h123456, 1'b0, NONE}
    };

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [LEVEL_W-1:0] s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;

    // sideband riding along with each offered sample
    logic     cur_typed = 1'b0;
    top_two_t cur_typed_res = '0;

    top_two_t expected_q [$];
    int       error_count     = 0;
    int       samples_sent    = 0;
    int       results_checked = 0;
    int       rcv_stall_pct   = 0;
    int       hold_requests   = 0;
    int       hold_served     = 0;
    int       hold_left       = 0;

    weighted_alarm_top_two_selector_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5ms;
        $display("timeout with %0d results still expected", expected_q.size());
        $display("== FAIL ==");
        $finish;
    end

    // top-two ranking over all candidates: combos first, then lines 0 upward
    function automatic top_two_t rank_top_two(input logic [LEVEL_W-1:0] lv);
        int unsigned cand_code [LINES + 2];
        int unsigned cand_wt [LINES + 2];
        bit          cand_on [LINES + 2];
        int unsigned best_code, best_wt, run_code, run_wt;
        top_two_t    r;
        best_code = 0;
        best_wt   = 0;
        run_code  = 0;
        run_wt    = 0;
        cand_on[0]   = !lv[13] && !lv[14] && !lv[15];
        cand_code[0] = 2 * LINES;
        cand_wt[0]   = 32'(W_COMBO_LOW);
        cand_on[1]   = lv[10] && lv[11];
        cand_code[1] = 2 * LINES + 1;
        cand_wt[1]   = 32'(W_COMBO_HIGH);
        for (int i = 0; i < LINES; i++) begin
            cand_on[i + 2]   = 1'b1;
            cand_code[i + 2] = lv[i] ? LINES + i : i;
            if (lv[i]) begin
                cand_wt[i + 2] = 32'((i == 9) ? W_BIT9_HIGH : W_OTHER_HIGH);
            end else if (i == 0) begin
                cand_wt[i + 2] = 32'(W_BIT0_LOW);
            end else if (i == 23) begin
                cand_wt[i + 2] = 32'(W_BIT23_LOW);
            end else begin
                cand_wt[i + 2] = 32'(W_OTHER_LOW);
            end
        end
        // strictly heavier displaces, so ties keep list order
        for (int k = 0; k < LINES + 2; k++) begin
            if (cand_on[k]) begin
                if (cand_wt[k] > best_wt) begin
                    run_code  = best_code;
                    run_wt    = best_wt;
                    best_code = cand_code[k];
                    best_wt   = cand_wt[k];
                end else if (cand_wt[k] > run_wt) begin
                    run_code = cand_code[k];
                    run_wt   = cand_wt[k];
                end
            end
        end
        r.first_code    = CODE_W'(best_code);
        r.first_weight  = WEIGHT_W'(best_wt);
        r.second_code   = CODE_W'(run_code);
        r.second_weight = WEIGHT_W'(run_wt);
        r.alert         = (best_wt != 0) && (best_code == 2 * LINES + 1);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned exp_val);
        error_count++;
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_checked, field, got, exp_val);
    endtask

    // scoreboard: record each accepted sample, compare each accepted result
    always @(posedge aclk) begin
        top_two_t got;
        top_two_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                want = cur_typed ? cur_typed_res : rank_top_two(s_tdata);
                expected_q.insert(expected_q.size(), want);
            end
            if (m_tvalid && m_tready) begin
                got.first_code    = m_tdata[5:0];
                got.first_weight  = m_tdata[9:6];
                got.second_code   = m_tdata[15:10];
                got.second_weight = m_tdata[19:16];
                got.alert         = m_tdata[20];
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 32'(m_tdata), 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.first_code !== want.first_code)
                        report_mismatch("first_code", 32'(got.first_code),
                                        32'(want.first_code));
                    if (got.first_weight !== want.first_weight)
                        report_mismatch("first_weight", 32'(got.first_weight),
                                        32'(want.first_weight));
                    if (got.second_code !== want.second_code)
                        report_mismatch("second_code", 32'(got.second_code),
                                        32'(want.second_code));
                    if (got.second_weight !== want.second_weight)
                        report_mismatch("second_weight", 32'(got.second_weight),
                                        32'(want.second_weight));
                    if (got.alert !== want.alert)
                        report_mismatch("alert", 32'(got.alert), 32'(want.alert));
                    if (m_tdata[23:21] !== 3'b000)
                        report_mismatch("pad", 32'(m_tdata[23:21]), 0);
                end
                results_checked++;
            end
        end
    end

    // receiver: random stalls, plus a long hold when requested
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != hold_served) begin
            m_tready    <= 1'b0;
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
        end
    end

    // offer one sample, optionally after an idle gap, and wait for its transaction
    task automatic send_sample(input logic [LEVEL_W-1:0] lv, input logic typed,
                               input top_two_t typed_res, input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_tvalid      <= 1'b1;
        s_tdata       <= lv;
        cur_typed     <= typed;
        cur_typed_res <= typed_res;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // random sample, biased toward the combination lines and sparse/dense patterns
    function automatic logic [LEVEL_W-1:0] shaped_levels();
        logic [LEVEL_W-1:0] lv;
        lv = LEVEL_W'($urandom);
        case ($urandom_range(0, 9))
            5, 6: lv[11:10] = 2'b11;
            7:    lv[15:13] = 3'b000;
            8:    lv = lv & LEVEL_W'($urandom) & LEVEL_W'($urandom);
            9:    lv = lv | LEVEL_W'($urandom) | LEVEL_W'($urandom);
            default: ;
        endcase
        return lv;
    endfunction

    // the first check waits for the scoreboard to run on the clock, so the last accepted sample is already queued
    task automatic wait_drained();
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // one phase of random samples; the sender pauses at its end until all results came
    task automatic run_phase(input int count, input int snd_idle, input int rcv_stall,
                             input bit long_hold);
        rcv_stall_pct = rcv_stall;
        for (int n = 0; n < count; n++) begin
            if (long_hold && n == count / 4) hold_requests++;
            send_sample(shaped_levels(), 1'b0, NONE, snd_idle);
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // main sequence
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, no idling
        for (int r = 0; r < NUM_DIR; r++) begin
            send_sample(DIR_ROWS[r].levels, DIR_ROWS[r].typed, DIR_ROWS[r].res, 0);
        end
        s_tvalid <= 1'b0;
        wait_drained();

        run_phase(RANDOM_PER_PHASE, 0, 0, 1'b0);
        run_phase(RANDOM_PER_PHASE, 81, 0, 1'b0);
        run_phase(RANDOM_PER_PHASE, 0, 81, 1'b0);
        run_phase(RANDOM_PER_PHASE, 36, 36, 1'b0);
        // back-pressure: receiver holds off while the sender keeps offering
        run_phase(RANDOM_PER_PHASE, 0, 0, 1'b1);

        repeat (PIPE_LATENCY + 8) @(posedge aclk);
        if (expected_q.size() != 0) begin
            error_count += expected_q.size();
            $display("%0d expected results never arrived", expected_q.size());
        end

        $display("covered %0d samples (%0d from the directed table) and %0d result transactions,",
                 samples_sent, NUM_DIR, results_checked);
        $display("under no idling, sender gaps, receiver stalls, both, and a long receiver hold");
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
